/* rtl/clje_pkg.sv */
// Shared types and constants for the circular list Josephus engine.
// Depends on nothing; clje_out_stage and the top level import it.
package clje_pkg;

    localparam int CAPACITY = 64;
    localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 16;
    localparam int REM_W    = 7;

    typedef enum logic [1:0] {
        ACT_INSERT   = 2'd0,
        ACT_DELETE   = 2'd1,
        ACT_SEARCH   = 2'd2,
        ACT_SIMULATE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_INSERTED   = 3'd0,
        ST_DELETED    = 3'd1,
        ST_FOUND      = 3'd2,
        ST_NOT_FOUND  = 3'd3,
        ST_ELIMINATED = 3'd4,
        ST_WINNER     = 3'd5,
        ST_FULL       = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_LINK,
        S_INS_LINK2,
        S_WALK_HEAD,
        S_WALK_CMP,
        S_SIM_CMP,
        S_SIM_RD,
        S_SIM_CUR,
        S_SIM_VIC,
        S_EMIT
    } state_t;

    typedef struct packed {
        status_t              status;
        logic [VALUE_W-1:0]   item_value;
        logic [REM_W-1:0]     remaining;
        logic                 last_of_run;
    } res_t;

endpackage

/* rtl/clje_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; used for the successor and value tables of the engine.
module clje_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/clje_out_stage.sv */
// Output register of the engine: holds one result transaction while the receiver stalls.
// Depends on clje_pkg for the result structure.
module clje_out_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  clje_pkg::res_t  push_data,
    output logic            push_ready,
    output logic            out_valid,
    input  logic            out_stall,
    output clje_pkg::res_t  out_data
);
    import clje_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t data_reg;

    // A new result may enter when the register is empty or is being taken now.
    assign push_ready = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (push_ready)
        begin
            valid_next = push_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ready && push_valid)
        begin
            data_reg <= push_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/circular_list_josephus_engine.sv */
// Top level of the circular list Josephus engine: control sequencer, ring tables, output stage.
// Depends on clje_pkg, clje_ram and clje_out_stage.
//
// Usage. The input channel (in_valid, in_stall, action, value) carries one command
// transaction: insert, delete, search or simulate elimination. The output channel
// (out_valid, out_stall, status, item_value, remaining, last_of_run) returns the
// results; last_of_run marks the final result of each command. Simulate gives one
// eliminated result per removed node and then the winner, or one not-found result; all others give one result.
// The block works on one command at a time: in_stall is low only while it is idle.
// Steps up to the result entering the output register: insert scans the free map for the
// lowest free slot, writes the value and links the node in; delete and search walk the
// ring node by node through the two tables; simulate first searches the start node,
// then for each eliminated node reads cur, reads the victim, writes back and hands the
// result to the output register, and for the winner reads cur and hands it off. An insert
// into a full list, or any other command on an empty list, answers without a scan or walk.
// The next command is taken once the final result has entered the output register.
// The tables are synchronous RAMs with a registered read; where the sequencer reads and
// writes the same entry in one cycle it never uses that read data, so no forwarding path
// is needed.
// Reset empties the list at once: the free map is set to all free, the count and tail
// clear, and the table contents are left as they are. When the receiver stalls, a
// result waits in the output register and the sequencer holds until it moves on.
module circular_list_josephus_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [15:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [15:0] item_value,
    output logic [6:0]  remaining,
    output logic        last_of_run
);
    import clje_pkg::*;

    // Control state.
    state_t               state_reg, state_next;
    state_t               ret_reg, ret_next;
    logic [CAPACITY-1:0]  free_map_reg, free_map_next;
    logic [SLOT_W-1:0]    tail_reg, tail_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    // Working registers of the current command.
    action_t              action_reg, action_next;
    logic [VALUE_W-1:0]   value_reg, value_next;
    logic [SLOT_W-1:0]    scan_reg, scan_next;
    logic [SLOT_W-1:0]    pos_reg, pos_next;
    logic [SLOT_W-1:0]    prev_reg, prev_next;
    logic [SLOT_W-1:0]    cur_reg, cur_next;
    logic [SLOT_W-1:0]    victim_reg, victim_next;
    logic [COUNT_W-1:0]   k_reg, k_next;
    res_t                 res_reg, res_next;

    // Table ports. Both tables are always read at the same slot.
    logic [SLOT_W-1:0]    rd_addr;
    logic                 succ_we;
    logic [SLOT_W-1:0]    succ_waddr;
    logic [SLOT_W-1:0]    succ_wdata;
    logic [SLOT_W-1:0]    succ_rdata;
    logic                 val_we;
    logic [SLOT_W-1:0]    val_waddr;
    logic [VALUE_W-1:0]   val_wdata;
    logic [VALUE_W-1:0]   val_rdata;

    // Output stage hand-off.
    logic                 push_valid;
    logic                 push_ready;
    res_t                 out_data;

    clje_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (CAPACITY)
    ) u_succ_ram (
        .clk   (clk),
        .we    (succ_we),
        .waddr (succ_waddr),
        .wdata (succ_wdata),
        .raddr (rd_addr),
        .rdata (succ_rdata)
    );

    clje_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (rd_addr),
        .rdata (val_rdata)
    );

    clje_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (res_reg),
        .push_ready (push_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    assign status      = out_data.status;
    assign item_value  = out_data.item_value;
    assign remaining   = out_data.remaining;
    assign last_of_run = out_data.last_of_run;

    // Sequencer: next state, table accesses and the result to hand off.
    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        free_map_next = free_map_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        action_next   = action_reg;
        value_next    = value_reg;
        scan_next     = scan_reg;
        pos_next      = pos_reg;
        prev_next     = prev_reg;
        cur_next      = cur_reg;
        victim_next   = victim_reg;
        k_next        = k_reg;
        res_next      = res_reg;

        rd_addr    = tail_reg;
        succ_we    = 1'b0;
        succ_waddr = tail_reg;
        succ_wdata = scan_reg;
        val_we     = 1'b0;
        val_waddr  = scan_reg;
        val_wdata  = value_reg;

        in_stall   = 1'b1;
        push_valid = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                // The tail is read here so that its entry is ready in the first walk cycle.
                in_stall = 1'b0;
                rd_addr  = tail_reg;
                if (in_valid)
                begin
                    action_next = action_t'(action);
                    value_next  = value;
                    k_next      = '0;
                    prev_next   = tail_reg;
                    cur_next    = tail_reg;
                    scan_next   = '0;
                    ret_next    = S_IDLE;
                    case (action_t'(action))
                        ACT_INSERT:
                        begin
                            if (count_reg >= COUNT_W'(CAPACITY))
                            begin
                                res_next   = '{ST_FULL, value, REM_W'(count_reg), 1'b1};
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_INS_SCAN;
                            end
                        end
                        ACT_DELETE, ACT_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next   = '{ST_NOT_FOUND, value, REM_W'(count_reg), 1'b1};
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_WALK_HEAD;
                            end
                        end
                        ACT_SIMULATE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next   = '{ST_NOT_FOUND, value, REM_W'(count_reg), 1'b1};
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_SIM_CMP;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_INS_SCAN:
            begin
                // Keep the tail entry on the read port for the link step.
                rd_addr = tail_reg;
                if (free_map_reg[scan_reg])
                begin
                    val_we     = 1'b1;
                    val_waddr  = scan_reg;
                    val_wdata  = value_reg;
                    state_next = S_INS_LINK;
                end
                else
                begin
                    scan_next = scan_reg + SLOT_W'(1);
                end
            end

            S_INS_LINK:
            begin
                succ_we    = 1'b1;
                succ_waddr = scan_reg;
                if (count_reg == '0)
                begin
                    succ_wdata    = scan_reg;
                    free_map_next[scan_reg] = 1'b0;
                    tail_next     = scan_reg;
                    count_next    = count_reg + COUNT_W'(1);
                    res_next      = '{ST_INSERTED, value_reg,
                                      REM_W'(count_reg + COUNT_W'(1)), 1'b1};
                    state_next    = S_EMIT;
                end
                else
                begin
                    succ_wdata = succ_rdata;
                    state_next = S_INS_LINK2;
                end
            end

            S_INS_LINK2:
            begin
                succ_we    = 1'b1;
                succ_waddr = tail_reg;
                succ_wdata = scan_reg;
                free_map_next[scan_reg] = 1'b0;
                tail_next  = scan_reg;
                count_next = count_reg + COUNT_W'(1);
                res_next   = '{ST_INSERTED, value_reg,
                               REM_W'(count_reg + COUNT_W'(1)), 1'b1};
                state_next = S_EMIT;
            end

            S_WALK_HEAD:
            begin
                rd_addr    = succ_rdata;
                pos_next   = succ_rdata;
                state_next = S_WALK_CMP;
            end

            S_WALK_CMP:
            begin
                // The entry of pos is on the read ports; fetch its successor meanwhile.
                rd_addr = succ_rdata;
                if (val_rdata == value_reg)
                begin
                    if (action_reg == ACT_SEARCH)
                    begin
                        res_next = '{ST_FOUND, value_reg, REM_W'(count_reg), 1'b1};
                    end
                    else
                    begin
                        if (count_reg == COUNT_W'(1))
                        begin
                            tail_next = '0;
                        end
                        else
                        begin
                            succ_we    = 1'b1;
                            succ_waddr = prev_reg;
                            succ_wdata = succ_rdata;
                            if (pos_reg == tail_reg)
                            begin
                                tail_next = prev_reg;
                            end
                        end
                        free_map_next[pos_reg] = 1'b1;
                        count_next = count_reg - COUNT_W'(1);
                        res_next   = '{ST_DELETED, value_reg,
                                       REM_W'(count_reg - COUNT_W'(1)), 1'b1};
                    end
                    state_next = S_EMIT;
                end
                else if (k_reg + COUNT_W'(1) == count_reg)
                begin
                    res_next   = '{ST_NOT_FOUND, value_reg, REM_W'(count_reg), 1'b1};
                    state_next = S_EMIT;
                end
                else
                begin
                    prev_next = pos_reg;
                    pos_next  = succ_rdata;
                    k_next    = k_reg + COUNT_W'(1);
                end
            end

            S_SIM_CMP:
            begin
                rd_addr = succ_rdata;
                if (val_rdata == value_reg)
                begin
                    state_next = S_SIM_RD;
                end
                else if (k_reg + COUNT_W'(1) == count_reg)
                begin
                    res_next   = '{ST_NOT_FOUND, value_reg, REM_W'(count_reg), 1'b1};
                    state_next = S_EMIT;
                end
                else
                begin
                    cur_next = succ_rdata;
                    k_next   = k_reg + COUNT_W'(1);
                end
            end

            S_SIM_RD:
            begin
                rd_addr    = cur_reg;
                state_next = S_SIM_CUR;
            end

            S_SIM_CUR:
            begin
                if (count_reg == COUNT_W'(1))
                begin
                    res_next   = '{ST_WINNER, val_rdata, REM_W'(count_reg), 1'b1};
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    victim_next = succ_rdata;
                    rd_addr     = succ_rdata;
                    state_next  = S_SIM_VIC;
                end
            end

            S_SIM_VIC:
            begin
                // Unlink the victim: its successor becomes the successor of cur.
                succ_we    = 1'b1;
                succ_waddr = cur_reg;
                succ_wdata = succ_rdata;
                if (victim_reg == tail_reg)
                begin
                    tail_next = cur_reg;
                end
                free_map_next[victim_reg] = 1'b1;
                count_next = count_reg - COUNT_W'(1);
                cur_next   = succ_rdata;
                res_next   = '{ST_ELIMINATED, val_rdata,
                               REM_W'(count_reg - COUNT_W'(1)), 1'b0};
                ret_next   = S_SIM_RD;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                push_valid = 1'b1;
                if (push_ready)
                begin
                    state_next = ret_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ret_reg      <= S_IDLE;
            free_map_reg <= '1;
            tail_reg     <= '0;
            count_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            free_map_reg <= free_map_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        value_reg  <= value_next;
        scan_reg   <= scan_next;
        pos_reg    <= pos_next;
        prev_reg   <= prev_next;
        cur_reg    <= cur_next;
        victim_reg <= victim_next;
        k_reg      <= k_next;
        res_reg    <= res_next;
    end

    // The count never goes past the number of slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("node count exceeds capacity");

    // Every node in the ring holds exactly one slot of the free map.
    a_free_map_sum: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(free_map_reg) == (CAPACITY - int'(count_reg)))
        else $error("free map and node count disagree");

    // A non-empty ring keeps its tail in an occupied slot.
    a_tail_used: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> !free_map_reg[tail_reg])
        else $error("tail slot is marked free");

    // An empty list always has its tail back at slot zero.
    a_empty_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (tail_reg == '0))
        else $error("empty list with nonzero tail");

endmodule
